// ===== rtl/lrut_pkg.sv =====
package lrut_pkg;

    // Default table size and fixed field widths.
    localparam int LRUT_FRAMES     = 64;
    localparam int LRUT_ADDR_W     = 32;
    localparam int LRUT_PAGE_W     = 20;
    localparam int LRUT_PAGE_SHIFT = 12;
    localparam int LRUT_FRAME_W    = 6;
    localparam int LRUT_CNT_W      = 32;
    localparam int LRUT_ACT_W      = 7;

    // Configuration port.
    localparam int LRUT_PADDR_W    = 3;
    localparam int LRUT_PDATA_W    = 32;
    localparam logic [LRUT_ACT_W-1:0] LRUT_ACT_RESET = 7'd64;

    // Register word indexes (byte address divided by four).
    typedef enum logic [0:0] {
        REG_ACTIVE_FRAMES = 1'b0
    } t_reg_idx;

    // Outcome of one table lookup, as reported in the result item.
    typedef struct packed {
        logic                    hit;
        logic                    evict;
        logic [LRUT_FRAME_W-1:0] frame_used;
        logic [LRUT_PAGE_W-1:0]  victim_page;
    } t_lookup;

endpackage

// ===== rtl/lrut_if.sv =====
interface lrut_req_if;
    import lrut_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [LRUT_ADDR_W-1:0] access_address;

    modport source (output valid, output access_address, input ready);
    modport sink   (input valid, input access_address, output ready);
endinterface

interface lrut_rsp_if;
    import lrut_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    was_hit;
    logic [LRUT_FRAME_W-1:0] frame_used;
    logic                    did_evict;
    logic [LRUT_PAGE_W-1:0]  victim_page;
    logic [LRUT_CNT_W-1:0]   hits_so_far;
    logic [LRUT_CNT_W-1:0]   misses_so_far;

    modport source (
        output valid, output was_hit, output frame_used, output did_evict,
        output victim_page, output hits_so_far, output misses_so_far,
        input ready
    );
    modport sink (
        input valid, input was_hit, input frame_used, input did_evict,
        input victim_page, input hits_so_far, input misses_so_far,
        output ready
    );
endinterface

// ===== rtl/lrut_table.sv =====
module lrut_table #(
    parameter int FRAMES = lrut_pkg::LRUT_FRAMES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic [lrut_pkg::LRUT_PAGE_W-1:0]    i_page,
    input  logic [lrut_pkg::LRUT_ACT_W-1:0]     i_active_frames,
    output lrut_pkg::t_lookup                   o_lookup
);
    import lrut_pkg::*;

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int LW = (CW > LRUT_ACT_W) ? CW : LRUT_ACT_W;

    // Tag store, valid bits and recency ranks (0 is most recently used).
    logic [LRUT_PAGE_W-1:0] r_page  [FRAMES];
    logic [FRAMES-1:0]      r_valid;
    logic [FW-1:0]          r_rank  [FRAMES];
    logic [CW-1:0]          r_filled;

    logic [FW-1:0]          n_rank  [FRAMES];
    logic [FRAMES-1:0]      n_valid;
    logic [CW-1:0]          n_filled;

    logic [FRAMES-1:0]      match;
    logic [FRAMES-1:0]      lru_sel;
    logic                   hit;
    logic [FW-1:0]          hit_idx;
    logic [FW-1:0]          hit_rank;
    logic                   lru_found;
    logic [FW-1:0]          lru_idx;
    logic [LRUT_PAGE_W-1:0] lru_page;
    logic [LW-1:0]          act_ext;
    logic [LW-1:0]          limit;
    logic                   fill;
    logic [FW-1:0]          frame;
    logic                   age_all;
    logic [FW-1:0]          old_rank;
    logic [CW-1:0]          lru_rank;

    // Effective frame limit: zero acts as one, values past the table size clamp.
    always_comb begin
        act_ext = LW'(i_active_frames);
        if (act_ext == '0) begin
            limit = LW'(1);
        end else if (act_ext > LW'(FRAMES)) begin
            limit = LW'(FRAMES);
        end else begin
            limit = act_ext;
        end
    end

    // Parallel tag compare and least recently used search. The oldest valid
    // frame always carries rank filled_count - 1, so the search is an equality
    // compare per frame.
    always_comb begin
        lru_rank  = r_filled - CW'(1);
        hit       = 1'b0;
        hit_idx   = '0;
        hit_rank  = '0;
        lru_found = 1'b0;
        lru_idx   = '0;
        lru_page  = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            match[i]   = r_valid[i] && (r_page[i] == i_page);
            lru_sel[i] = r_valid[i] && (CW'(r_rank[i]) == lru_rank);
            if (match[i]) begin
                hit      = 1'b1;
                hit_idx  = FW'(i);
                hit_rank = r_rank[i];
            end
            if (lru_sel[i]) begin
                lru_found = 1'b1;
                lru_idx   = FW'(i);
                lru_page  = r_page[i];
            end
        end
    end

    // Choose the frame and the aging rule for this access.
    always_comb begin
        fill = !hit && (LW'(r_filled) < limit) && (r_filled < CW'(FRAMES));
        priority if (hit) begin
            frame    = hit_idx;
            age_all  = 1'b0;
            old_rank = hit_rank;
        end else if (fill || !lru_found) begin
            frame    = fill ? r_filled[FW-1:0] : '0;
            age_all  = 1'b1;
            old_rank = '0;
        end else begin
            frame    = lru_idx;
            age_all  = 1'b0;
            old_rank = lru_rank[FW-1:0];
        end

        o_lookup.hit         = hit;
        o_lookup.evict       = !hit && !fill && lru_found;
        o_lookup.frame_used  = LRUT_FRAME_W'(frame);
        o_lookup.victim_page = o_lookup.evict ? lru_page : '0;
    end

    // Next ranks, valid bits and fill count.
    always_comb begin
        n_valid  = r_valid;
        n_filled = r_filled;
        if (!hit) begin
            n_valid[frame] = 1'b1;
        end
        if (fill) begin
            n_filled = r_filled + CW'(1);
        end else if (!hit && !lru_found && r_filled == '0) begin
            n_filled = CW'(1);
        end
        for (int i = 0; i < FRAMES; i++) begin
            if (FW'(i) == frame) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (age_all || r_rank[i] < old_rank)) begin
                n_rank[i] = r_rank[i] + FW'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    // Control state of the table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_filled <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_go) begin
            r_valid  <= n_valid;
            r_filled <= n_filled;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    // Page tags are written on every miss and need no reset.
    always_ff @(posedge i_clk) begin
        if (i_go && !hit) begin
            r_page[frame] <= i_page;
        end
    end

endmodule

// ===== rtl/lrut_stats.sv =====
module lrut_stats (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_go,
    input  logic                               i_hit,
    output logic [lrut_pkg::LRUT_CNT_W-1:0]    o_hits,
    output logic [lrut_pkg::LRUT_CNT_W-1:0]    o_misses
);
    import lrut_pkg::*;

    logic [LRUT_CNT_W-1:0] r_hits;
    logic [LRUT_CNT_W-1:0] r_misses;
    logic [LRUT_CNT_W-1:0] n_hits;
    logic [LRUT_CNT_W-1:0] n_misses;

    // Saturating counts that include the access being processed.
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (i_hit && r_hits != '1) begin
            n_hits = r_hits + LRUT_CNT_W'(1);
        end
        if (!i_hit && r_misses != '1) begin
            n_misses = r_misses + LRUT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_misses <= '0;
        end else if (i_go) begin
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

    assign o_hits   = n_hits;
    assign o_misses = n_misses;

endmodule

// ===== rtl/lru_tlb_page_replacement.sv =====
// Fully associative translation table with least recently used replacement.
// The request channel i_req carries one access address per item; the page
// number is address bits 31 down to 12. The response channel o_rsp returns
// one item per request: hit flag, frame used, eviction flag, evicted page
// and saturating running hit and miss counts.
// An accepted request is registered in the input register and then moves into
// the response register, from which o_rsp presents it.
// Throughput is one item per cycle while o_rsp is not stalled: the tag
// compare over all frames, the victim pick and the rank update sit between
// the input register and the response register.
// When o_rsp is stalled, one more item is held in the input register and then
// i_req.ready drops until the response is taken.
// The APB port holds active_frames at address 0 (reset value 64). Changing it
// is meant to be followed by a reset. Reset (i_rst_n low, synchronous) empties
// the table, clears all ranks and counts and drops both valid flags; it needs
// no clearing pass.
module lru_tlb_page_replacement #(
    parameter int FRAMES = lrut_pkg::LRUT_FRAMES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    lrut_req_if.sink                             i_req,
    lrut_rsp_if.source                           o_rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrut_pkg::LRUT_PADDR_W-1:0]    paddr,
    input  logic [lrut_pkg::LRUT_PDATA_W-1:0]    pwdata,
    output logic [lrut_pkg::LRUT_PDATA_W-1:0]    prdata,
    output logic                                 pready
);
    import lrut_pkg::*;

    logic                   r_in_valid;
    logic [LRUT_ADDR_W-1:0] r_in_addr;
    logic                   r_out_valid;
    t_lookup                r_out;
    logic [LRUT_CNT_W-1:0]  r_out_hits;
    logic [LRUT_CNT_W-1:0]  r_out_misses;
    logic [LRUT_ACT_W-1:0]  r_active_frames;

    logic                   advance;
    logic                   sel_active;
    t_lookup                lookup;
    logic [LRUT_CNT_W-1:0]  hits;
    logic [LRUT_CNT_W-1:0]  misses;

    // Handshake: the input register moves into the response register whenever
    // the response register is empty or being drained.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_addr <= i_req.access_address;
        end
        if (advance) begin
            r_out        <= lookup;
            r_out_hits   <= hits;
            r_out_misses <= misses;
        end
    end

    lrut_table #(
        .FRAMES (FRAMES)
    ) u_table (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_go            (advance),
        .i_page          (r_in_addr[LRUT_ADDR_W-1:LRUT_PAGE_SHIFT]),
        .i_active_frames (r_active_frames),
        .o_lookup        (lookup)
    );

    lrut_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (advance),
        .i_hit    (lookup.hit),
        .o_hits   (hits),
        .o_misses (misses)
    );

    // Response channel.
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.was_hit       = r_out.hit;
    assign o_rsp.frame_used    = r_out.frame_used;
    assign o_rsp.did_evict     = r_out.evict;
    assign o_rsp.victim_page   = r_out.victim_page;
    assign o_rsp.hits_so_far   = r_out_hits;
    assign o_rsp.misses_so_far = r_out_misses;

    // Configuration register, decoded by word index.
    assign sel_active = (paddr[LRUT_PADDR_W-1:2] == REG_ACTIVE_FRAMES);
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_frames <= LRUT_ACT_RESET;
        end else if (psel && penable && pwrite && sel_active) begin
            r_active_frames <= pwdata[LRUT_ACT_W-1:0];
        end
    end

    assign prdata = sel_active ? LRUT_PDATA_W'(r_active_frames) : '0;

endmodule

// ===== rtl/lrut_checker.sv =====
module lrut_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_was_hit,
    input logic [5:0]  i_frame_used,
    input logic        i_did_evict,
    input logic [19:0] i_victim_page,
    input logic [31:0] i_hits_so_far,
    input logic [31:0] i_misses_so_far
);

    // A stalled response keeps its item.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_frame_used)
            && $stable(i_hits_so_far) && $stable(i_misses_so_far))
        else $error("response changed while stalled");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_was_hit |-> !i_did_evict)
        else $error("hit reported an eviction");

    // The victim page is zero unless a page was evicted.
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_did_evict |-> i_victim_page == 20'd0)
        else $error("victim page set without eviction");

    // Every response counts its own access.
    a_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_was_hit && i_hits_so_far != 32'd0)
            || (!i_was_hit && i_misses_so_far != 32'd0))
        else $error("response not reflected in running counts");

endmodule

bind lru_tlb_page_replacement lrut_checker u_lrut_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_was_hit       (o_rsp.was_hit),
    .i_frame_used    (o_rsp.frame_used),
    .i_did_evict     (o_rsp.did_evict),
    .i_victim_page   (o_rsp.victim_page),
    .i_hits_so_far   (o_rsp.hits_so_far),
    .i_misses_so_far (o_rsp.misses_so_far)
);

// ===== tb/lru_tlb_page_replacement_tb.sv =====
module lru_tlb_page_replacement_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrut_pkg::*;

    localparam int NFR         = LRUT_FRAMES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 96;

    // Expected content of one result item.
    typedef struct {
        t_lookup                lk;
        logic [LRUT_CNT_W-1:0]  hits;
        logic [LRUT_CNT_W-1:0]  misses;
    } t_access_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [LRUT_PADDR_W-1:0] paddr;
    logic [LRUT_PDATA_W-1:0] pwdata;
    logic [LRUT_PDATA_W-1:0] prdata;
    logic                    pready;

    lrut_req_if req_ch ();
    lrut_rsp_if rsp_ch ();

    lru_tlb_page_replacement dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the translation table and its counters.
    logic [LRUT_PAGE_W-1:0] tlb_page [NFR];
    bit                     tlb_valid [NFR];
    int                     tlb_rank [NFR];
    int                     tlb_filled;
    logic [LRUT_ACT_W-1:0]  tlb_active;
    logic [LRUT_CNT_W-1:0]  tlb_hits;
    logic [LRUT_CNT_W-1:0]  tlb_misses;

    t_access_result         expected_lookups [$];
    logic [LRUT_PAGE_W-1:0] page_pool [POOL_SIZE];

    int err_count;
    int cycle_count;
    int req_gap_pct;
    int rsp_stall_pct;
    int rsp_hold_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lru_tlb_page_replacement_tb failed");
            $finish;
        end
    end

    // Make frame f the most recently used; frames more recent than it age by one.
    function automatic void age_frames(int f, int old_rank);
        for (int i = 0; i < NFR; i++) begin
            if (i != f && tlb_valid[i] && tlb_rank[i] < old_rank) begin
                tlb_rank[i]++;
            end
        end
        tlb_rank[f] = 0;
    endfunction

    // Work out the result of one accepted access and queue it.
    function automatic void predict_lookup(logic [LRUT_ADDR_W-1:0] addr);
        logic [LRUT_PAGE_W-1:0] pg;
        logic [LRUT_PAGE_W-1:0] victim;
        int                     f;
        int                     oldest;
        int                     lim;
        bit                     hit;
        bit                     ev;
        bit                     found;
        t_access_result         r;
        pg = addr[LRUT_ADDR_W-1:LRUT_PAGE_SHIFT];
        f = 0;
        oldest = 0;
        hit = 1'b0;
        ev = 1'b0;
        found = 1'b0;
        victim = '0;
        for (int i = 0; i < NFR; i++) begin
            if (tlb_valid[i] && tlb_page[i] == pg) begin
                hit = 1'b1;
                f = i;
                break;
            end
        end
        if (hit) begin
            if (tlb_hits != '1) tlb_hits++;
            age_frames(f, tlb_rank[f]);
        end else begin
            if (tlb_misses != '1) tlb_misses++;
            // A zero limit acts as one frame, anything above the table size as all.
            lim = (tlb_active == 0) ? 1 : ((tlb_active > NFR) ? NFR : int'(tlb_active));
            if (tlb_filled < lim) begin
                f = tlb_filled;
                tlb_filled++;
                tlb_valid[f] = 1'b1;
                tlb_page[f] = pg;
                age_frames(f, NFR);
            end else begin
                // Least recently used valid frame, lowest index on equal rank.
                for (int i = 0; i < NFR; i++) begin
                    if (tlb_valid[i] && (!found || tlb_rank[i] > oldest)) begin
                        oldest = tlb_rank[i];
                        f = i;
                        found = 1'b1;
                    end
                end
                ev = 1'b1;
                victim = tlb_page[f];
                tlb_page[f] = pg;
                age_frames(f, oldest);
            end
        end
        r.lk.hit = hit;
        r.lk.evict = ev;
        r.lk.frame_used = LRUT_FRAME_W'(f);
        r.lk.victim_page = victim;
        r.hits = tlb_hits;
        r.misses = tlb_misses;
        expected_lookups.push_back(r);
    endfunction

    // Offer one access item and record its expected result once accepted.
    task automatic send_access(input logic [LRUT_ADDR_W-1:0] addr);
        while ($urandom_range(99) < req_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.access_address <= addr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predict_lookup(addr);
        @(negedge i_clk);
    endtask

    // Mostly pages from a small pool so that hits are common; some fully random.
    function automatic logic [LRUT_ADDR_W-1:0] pick_address(int pool_n);
        logic [LRUT_PAGE_W-1:0] pg;
        if ($urandom_range(99) < 10) return $urandom;
        pg = page_pool[$urandom_range(pool_n - 1)];
        return {pg, 12'($urandom)};
    endfunction

    task automatic run_random(input int n, input int pool_n);
        for (int k = 0; k < n; k++) begin
            send_access(pick_address(pool_n));
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (expected_lookups.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write active_frames over the APB port while idle and read it back.
    task automatic set_active_frames(input logic [LRUT_ACT_W-1:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LRUT_PADDR_W'(int'(REG_ACTIVE_FRAMES) * 4);
        pwdata <= LRUT_PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== LRUT_PDATA_W'(value)) begin
            err_count++;
            $display("%0t ns: active_frames read back expected %0h, got %0h",
                     $time, value, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tlb_active = value;
    endtask

    // Receiver: random stalls, plus a long hold-off counted down here.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        t_access_result exp_r;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_lookups.size() == 0) begin
                err_count++;
                $display("%0t ns: result item with none expected", $time);
            end else begin
                exp_r = expected_lookups.pop_front();
                check_field("was_hit", 32'(exp_r.lk.hit), 32'(rsp_ch.was_hit));
                check_field("frame_used", 32'(exp_r.lk.frame_used), 32'(rsp_ch.frame_used));
                check_field("did_evict", 32'(exp_r.lk.evict), 32'(rsp_ch.did_evict));
                check_field("victim_page", 32'(exp_r.lk.victim_page),
                            32'(rsp_ch.victim_page));
                check_field("hits_so_far", exp_r.hits, rsp_ch.hits_so_far);
                check_field("misses_so_far", exp_r.misses, rsp_ch.misses_so_far);
            end
        end
    end

    // A one-frame table: after the first fill every new page evicts frame 0; a zero limit acts the same.
    task automatic test_single_frame();
        set_active_frames(7'd1);
        send_access(32'h0000_0000);
        send_access(32'h0000_0FFF);
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_F000);
        send_access(32'h1234_5678);
        set_active_frames(7'd0);
        send_access(32'h0000_1000);
        send_access(32'h0000_1ABC);
        send_access(32'hAAAA_A555);
        send_access(32'h5555_5AAA);
    endtask

    // Four frames: fill, reorder by hits, then evict the least recently used.
    task automatic test_small_table();
        set_active_frames(7'd4);
        send_access(32'h0001_0123);
        send_access(32'h0002_0456);
        send_access(32'h0003_0789);
        send_access(32'h0001_0FFF);
        send_access(32'h5555_5AAA);
        send_access(32'h0004_0000);
        send_access(32'h0003_0001);
        send_access(32'h0005_0000);
        run_random(150, 6);
    endtask

    // Limit above the table size fills all frames.
    task automatic test_full_table();
        set_active_frames(7'd127);
        run_random(400, POOL_SIZE);
    endtask

    // Back to back items with no stalls on either side.
    task automatic test_no_idle();
        req_gap_pct = 0;
        rsp_stall_pct = 0;
        run_random(300, POOL_SIZE);
        req_gap_pct = 8;
        rsp_stall_pct = 8;
    endtask

    // Receiver holds off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        req_gap_pct = 0;
        rsp_hold_cycles = 300;
        run_random(100, POOL_SIZE);
        req_gap_pct = 8;
    endtask

    // Lowering the limit without a reset keeps all filled frames in use.
    task automatic test_shrunk_limit();
        set_active_frames(7'd64);
        run_random(100, POOL_SIZE);
        set_active_frames(7'd10);
        run_random(300, POOL_SIZE);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.access_address = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        err_count = 0;
        cycle_count = 0;
        req_gap_pct = 8;
        rsp_stall_pct = 8;
        rsp_hold_cycles = 0;
        for (int i = 0; i < NFR; i++) begin
            tlb_page[i] = '0;
            tlb_valid[i] = 1'b0;
            tlb_rank[i] = 0;
        end
        tlb_filled = 0;
        tlb_active = LRUT_ACT_RESET;
        tlb_hits = '0;
        tlb_misses = '0;
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = LRUT_PAGE_W'($urandom);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_single_frame();
        test_small_table();
        test_full_table();
        test_no_idle();
        test_backpressure();
        test_shrunk_limit();

        drain_results();
        if (err_count == 0) begin
            $display("lru_tlb_page_replacement_tb passed");
        end else begin
            $display("lru_tlb_page_replacement_tb failed");
        end
        $finish;
    end

endmodule
